[src/nls_pkg.sv]
// shared types and constants for the numeric literal scanner
package nls_pkg;

   // scanner phase within one token
   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_ZERO    = 4'd1,
      PH_DEC     = 4'd2,
      PH_OCT     = 4'd3,
      PH_BIG     = 4'd4,
      PH_HEX     = 4'd5,
      PH_FRAC    = 4'd6,
      PH_EXPSIGN = 4'd7,
      PH_EXPDIG0 = 4'd8,
      PH_EXPDIG  = 4'd9,
      PH_SUFFIX  = 4'd10,
      PH_ERR     = 4'd11
   } phase_type;

   // radix codes as reported in the result
   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_DIGIT   = 3'd1,
      ERR_EXP     = 3'd2,
      ERR_HEX_EXP = 3'd3,
      ERR_SUFFIX  = 3'd4
   } err_type;

   // flags gathered over one token
   typedef struct packed {
      logic point;
      logic expo;
      logic uns;
      logic lng;
      logic llng;
      logic flt;
   } flags_type;

   localparam int OUT_VALUE_BITS = 64;

   // one input item
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   // one result item
   typedef struct packed {
      logic [1:0]                base;
      logic                      has_point;
      logic                      has_exp;
      logic                      sfx_unsigned;
      logic                      sfx_long;
      logic                      sfx_long_long;
      logic                      sfx_float;
      logic [2:0]                err;
      logic [OUT_VALUE_BITS-1:0] int_value;
      logic                      overflow;
   } rsp_type;

endpackage

[src/numeric_literal_scanner.sv]
// top level of the numeric literal scanner
//
// Scans a C numeric constant one character per item, at a sustained rate of one
// item per cycle while no waiting result holds back a last character. Each
// accepted character goes into an input register; from there a single pass of
// logic (radix/suffix state update plus a shift-add by the constant radix on the
// accumulator) updates the token state, and on the item marked last it loads the
// result register, which presents the result. A result waiting under rsp_stall
// holds back only a following last character; other characters keep flowing.
// All token state returns to its reset value after every result.
module numeric_literal_scanner
   import nls_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int WIDE = VALUE_BITS + 4;

   // input register
   logic    in_valid_ff;
   req_type in_item_ff;

   // token state
   phase_type             phase_ff, phase_in;
   radix_type             radix_ff, radix_in;
   flags_type             flags_ff, flags_in;
   logic [7:0]            pend_l_ff, pend_l_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic                  dig_seen_ff, dig_seen_in;
   err_type               err_ff, err_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // handshake
   logic advance;
   logic process;

   assign advance   = !(in_item_ff.last && rsp_valid_ff && rsp_stall);
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // character classes
   logic [7:0] ch;
   logic       is_dig, is_oct, is_hex, is_e, is_p;
   logic [3:0] dval;

   assign ch     = in_item_ff.ch;
   assign is_dig = (ch >= "0") && (ch <= "9");
   assign is_oct = (ch >= "0") && (ch <= "7");
   assign is_hex = is_dig || ((ch >= "a") && (ch <= "f")) || ((ch >= "A") && (ch <= "F"));
   assign is_e   = (ch == "e") || (ch == "E");
   assign is_p   = (ch == "p") || (ch == "P");
   assign dval   = is_dig ? ch[3:0] : ch[3:0] + 4'd9;

   // shift-add by the constant radix, with carry-out for overflow
   radix_type       acc_rx;
   logic [WIDE-1:0] acc_x, acc_wide;

   assign acc_x = WIDE'(acc_ff);

   always_comb begin
      case (acc_rx)
         RX_DEC:  acc_wide = (acc_x << 3) + (acc_x << 1) + WIDE'(dval);
         RX_OCT:  acc_wide = (acc_x << 3) + WIDE'(dval);
         default: acc_wide = (acc_x << 4) + WIDE'(dval);
      endcase
   end

   // per-character state update and end-of-token result
   logic      do_acc, do_dec_end, do_hex_end, do_sfx, sfx_done, is_fp;
   phase_type f_phase;
   radix_type f_radix;
   flags_type f_flags;
   err_type   f_err;
   logic      valid_int;

   always_comb begin
      phase_in    = phase_ff;
      radix_in    = radix_ff;
      flags_in    = flags_ff;
      pend_l_in   = pend_l_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      dig_seen_in = dig_seen_ff;
      err_in      = err_ff;
      acc_rx      = RX_DEC;
      do_acc      = 1'b0;
      do_dec_end  = 1'b0;
      do_hex_end  = 1'b0;
      do_sfx      = 1'b0;
      sfx_done    = 1'b0;

      // main phase dispatch
      unique case (phase_ff)
         PH_START: begin
            if (ch == "0") begin
               phase_in = PH_ZERO;
            end else begin
               radix_in = RX_DEC;
               if (is_dig) begin
                  phase_in = PH_DEC;
                  do_acc   = 1'b1;
               end else begin
                  do_dec_end = 1'b1;
               end
            end
         end
         PH_ZERO: begin
            if ((ch == "x") || (ch == "X")) begin
               radix_in = RX_HEX;
               phase_in = PH_HEX;
            end else begin
               radix_in = RX_OCT;
               phase_in = PH_OCT;
               if (is_oct) begin
                  do_acc = 1'b1;
                  acc_rx = RX_OCT;
               end else if (is_dig) begin
                  phase_in = PH_BIG;
               end else begin
                  do_dec_end = 1'b1;
               end
            end
         end
         PH_DEC: begin
            if (is_dig) do_acc = 1'b1;
            else do_dec_end = 1'b1;
         end
         PH_OCT: begin
            if (is_oct) begin
               do_acc = 1'b1;
               acc_rx = RX_OCT;
            end else if (is_dig) begin
               phase_in = PH_BIG;
            end else begin
               do_dec_end = 1'b1;
            end
         end
         PH_BIG: begin
            if (!is_dig) begin
               if ((ch == ".") || is_e) begin
                  radix_in   = RX_DEC;
                  do_dec_end = 1'b1;
               end else begin
                  err_in   = ERR_DIGIT;
                  phase_in = PH_ERR;
               end
            end
         end
         PH_HEX: begin
            if (is_hex) begin
               do_acc = 1'b1;
               acc_rx = RX_HEX;
            end else begin
               do_hex_end = 1'b1;
            end
         end
         PH_FRAC: begin
            if (radix_ff == RX_HEX) begin
               if (!is_hex) do_hex_end = 1'b1;
            end else if (!is_dig) begin
               if (is_e) begin
                  flags_in.expo = 1'b1;
                  phase_in      = PH_EXPSIGN;
               end else begin
                  do_sfx = 1'b1;
               end
            end
         end
         PH_EXPSIGN: begin
            if ((ch == "+") || (ch == "-")) phase_in = PH_EXPDIG0;
            else if (is_dig) phase_in = PH_EXPDIG;
            else begin
               err_in   = ERR_EXP;
               phase_in = PH_ERR;
            end
         end
         PH_EXPDIG0: begin
            if (is_dig) phase_in = PH_EXPDIG;
            else begin
               err_in   = ERR_EXP;
               phase_in = PH_ERR;
            end
         end
         PH_EXPDIG: begin
            if (!is_dig) do_sfx = 1'b1;
         end
         PH_SUFFIX: begin
            do_sfx = 1'b1;
         end
         default: begin
         end
      endcase

      // first non-digit after a decimal or octal integer part
      if (do_dec_end) begin
         if (is_hex && !is_e) begin
            err_in   = ERR_DIGIT;
            phase_in = PH_ERR;
         end else if (ch == ".") begin
            flags_in.point = 1'b1;
            radix_in       = RX_DEC;
            phase_in       = PH_FRAC;
         end else if (is_e) begin
            flags_in.expo = 1'b1;
            radix_in      = RX_DEC;
            phase_in      = PH_EXPSIGN;
         end else begin
            do_sfx = 1'b1;
         end
      end

      // first non-hex-digit of a hex mantissa
      if (do_hex_end) begin
         if ((ch == ".") && (phase_ff == PH_HEX)) begin
            flags_in.point = 1'b1;
            phase_in       = PH_FRAC;
         end else if (is_p) begin
            flags_in.expo = 1'b1;
            phase_in      = PH_EXPSIGN;
         end else if (flags_in.point) begin
            err_in   = ERR_HEX_EXP;
            phase_in = PH_ERR;
         end else begin
            do_sfx = 1'b1;
         end
      end

      // suffix characters, with one l held back to pair into ll
      is_fp = flags_in.point || flags_in.expo;
      if (do_sfx) begin
         phase_in = PH_SUFFIX;
         if (pend_l_in != 8'd0) begin
            if (ch == pend_l_in) begin
               pend_l_in = 8'd0;
               sfx_done  = 1'b1;
               if (is_fp) begin
                  err_in   = ERR_SUFFIX;
                  phase_in = PH_ERR;
               end else begin
                  flags_in.llng = 1'b1;
               end
            end else begin
               flags_in.lng = 1'b1;
               pend_l_in    = 8'd0;
            end
         end
         if (!sfx_done) begin
            if ((ch == "u") || (ch == "U")) begin
               if (is_fp || flags_in.uns) begin
                  err_in   = ERR_SUFFIX;
                  phase_in = PH_ERR;
               end else begin
                  flags_in.uns = 1'b1;
               end
            end else if ((ch == "l") || (ch == "L")) begin
               if (flags_in.lng || flags_in.llng) begin
                  err_in   = ERR_SUFFIX;
                  phase_in = PH_ERR;
               end else begin
                  pend_l_in = ch;
               end
            end else if ((ch == "f") || (ch == "F")) begin
               if (!is_fp || flags_in.flt) begin
                  err_in   = ERR_SUFFIX;
                  phase_in = PH_ERR;
               end else begin
                  flags_in.flt = 1'b1;
               end
            end else begin
               err_in   = ERR_SUFFIX;
               phase_in = PH_ERR;
            end
         end
      end

      // digit accumulation
      if (do_acc) begin
         acc_in      = acc_wide[VALUE_BITS-1:0];
         dig_seen_in = 1'b1;
         if (|acc_wide[WIDE-1:VALUE_BITS]) ovf_in = 1'b1;
      end

      // end-of-token checks
      f_phase = phase_in;
      f_err   = err_in;
      f_flags = flags_in;
      f_radix = radix_in;
      if (phase_in == PH_BIG) begin
         f_err   = ERR_DIGIT;
         f_phase = PH_ERR;
      end else if ((phase_in == PH_EXPSIGN) || (phase_in == PH_EXPDIG0)) begin
         f_err   = ERR_EXP;
         f_phase = PH_ERR;
      end else if ((phase_in == PH_FRAC) && (radix_in == RX_HEX)) begin
         f_err   = ERR_HEX_EXP;
         f_phase = PH_ERR;
      end
      if ((f_phase != PH_ERR) && (pend_l_in != 8'd0)) f_flags.lng = 1'b1;
      // a lone zero, or zero with only a suffix, reads as decimal
      if (((f_err == ERR_NONE) || (f_err == ERR_SUFFIX)) &&
          ((radix_in == RX_OCT) || (phase_in == PH_ZERO)) &&
          !dig_seen_in && (radix_in != RX_HEX)) begin
         f_radix = RX_DEC;
      end

      valid_int                 = (f_err == ERR_NONE) && !(f_flags.point || f_flags.expo);
      rsp_data_in.base          = f_radix;
      rsp_data_in.has_point     = f_flags.point;
      rsp_data_in.has_exp       = f_flags.expo;
      rsp_data_in.sfx_unsigned  = f_flags.uns;
      rsp_data_in.sfx_long      = f_flags.lng;
      rsp_data_in.sfx_long_long = f_flags.llng;
      rsp_data_in.sfx_float     = f_flags.flt;
      rsp_data_in.err           = f_err;
      rsp_data_in.int_value     = valid_int ? OUT_VALUE_BITS'(acc_in) : '0;
      rsp_data_in.overflow      = valid_int && ovf_in;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) in_item_ff <= req_data;
   end

   // token state, cleared after every result
   always_ff @(posedge clock) begin
      if (reset || (process && in_item_ff.last)) begin
         phase_ff    <= PH_START;
         radix_ff    <= RX_DEC;
         flags_ff    <= '0;
         pend_l_ff   <= 8'd0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         dig_seen_ff <= 1'b0;
         err_ff      <= ERR_NONE;
      end else if (process) begin
         phase_ff    <= phase_in;
         radix_ff    <= radix_in;
         flags_ff    <= flags_in;
         pend_l_ff   <= pend_l_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         dig_seen_ff <= dig_seen_in;
         err_ff      <= err_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && in_item_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (process && in_item_ff.last) rsp_data_ff <= rsp_data_in;
   end

endmodule

[src/nls_checker.sv]
// port-level checks for the numeric literal scanner, bound to the top level
module nls_checker
   import nls_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // the value fields are cleared on any error
   a_err_clears_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.err != ERR_NONE) |-> (rsp_data.int_value == '0) && !rsp_data.overflow)
      else $error("value fields set on an item with an error");

   // overflow is only reported for integer tokens
   a_ovf_int_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> !rsp_data.has_point && !rsp_data.has_exp)
      else $error("overflow reported on a floating token");

   // float suffix only on a floating token
   a_float_sfx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sfx_float |-> rsp_data.has_point || rsp_data.has_exp)
      else $error("float suffix on an integer token");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (.*);

[tb/numeric_literal_scanner_test.sv]
// self-checking testbench for the numeric literal scanner
`timescale 1ns / 100ps

module numeric_literal_scanner_test;
   import nls_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int CHAR_TARGET = 750;
   localparam int IDLE_PCT = 8;

   // tracks one token at a time and keeps the results it predicts
   class literal_tracker;
      phase_type phase;
      radix_type radix;
      flags_type flags;
      logic [7:0] pend_l;
      logic [63:0] acc;
      logic ovf;
      logic [4:0] ndigits;
      err_type errc;
      rsp_type due_results[$];
      int failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         phase = PH_START;
         radix = RX_DEC;
         flags = '0;
         pend_l = 8'h00;
         acc = '0;
         ovf = 1'b0;
         ndigits = '0;
         errc = ERR_NONE;
      endfunction

      function bit is_dig(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_oct(logic [7:0] c);
         return c >= "0" && c <= "7";
      endfunction

      function bit is_hex(logic [7:0] c);
         return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function bit fp_token();
         return flags.point || flags.expo;
      endfunction

      function void fail_with(err_type code);
         errc = code;
         phase = PH_ERR;
      endfunction

      // shift-add one digit, noting a true overflow of 64 bits
      function void add_digit(logic [7:0] c, logic [63:0] rdx);
         logic [63:0] d;
         if (is_dig(c)) d = 64'(c - "0");
         else if (c >= "a" && c <= "f") d = 64'(c - "a") + 64'd10;
         else d = 64'(c - "A") + 64'd10;
         if (acc > ({64{1'b1}} - d) / rdx) ovf = 1'b1;
         acc = acc * rdx + d;
         if (ndigits < 5'd31) ndigits++;
      endfunction

      // u, l, ll and f suffixes; an l waits one character to see if it doubles
      function void suffix_char(logic [7:0] c);
         phase = PH_SUFFIX;
         if (pend_l != 8'h00) begin
            if (c == pend_l) begin
               pend_l = 8'h00;
               if (fp_token()) fail_with(ERR_SUFFIX);
               else flags.llng = 1'b1;
               return;
            end
            flags.lng = 1'b1;
            pend_l = 8'h00;
         end
         if (c == "u" || c == "U") begin
            if (fp_token() || flags.uns) fail_with(ERR_SUFFIX);
            else flags.uns = 1'b1;
         end else if (c == "l" || c == "L") begin
            if (flags.lng || flags.llng) fail_with(ERR_SUFFIX);
            else pend_l = c;
         end else if (c == "f" || c == "F") begin
            if (!fp_token() || flags.flt) fail_with(ERR_SUFFIX);
            else flags.flt = 1'b1;
         end else begin
            fail_with(ERR_SUFFIX);
         end
      endfunction

      // first non-digit after a decimal or octal integer part
      function void int_end(logic [7:0] c);
         if (is_hex(c) && c != "e" && c != "E") begin
            fail_with(ERR_DIGIT);
         end else if (c == ".") begin
            flags.point = 1'b1;
            radix = RX_DEC;
            phase = PH_FRAC;
         end else if (c == "e" || c == "E") begin
            flags.expo = 1'b1;
            radix = RX_DEC;
            phase = PH_EXPSIGN;
         end else begin
            suffix_char(c);
         end
      endfunction

      // first non-hex-digit of a hex mantissa
      function void hex_end(logic [7:0] c);
         if (c == "." && phase == PH_HEX) begin
            flags.point = 1'b1;
            phase = PH_FRAC;
         end else if (c == "p" || c == "P") begin
            flags.expo = 1'b1;
            phase = PH_EXPSIGN;
         end else if (flags.point) begin
            fail_with(ERR_HEX_EXP);
         end else begin
            suffix_char(c);
         end
      endfunction

      function void octal_char(logic [7:0] c);
         if (is_oct(c)) add_digit(c, 64'd8);
         else if (is_dig(c)) phase = PH_BIG;
         else int_end(c);
      endfunction

      function void advance_scan(logic [7:0] c);
         case (phase)
            PH_START: begin
               if (c == "0") begin
                  phase = PH_ZERO;
               end else begin
                  radix = RX_DEC;
                  if (is_dig(c)) begin
                     phase = PH_DEC;
                     add_digit(c, 64'd10);
                  end else begin
                     int_end(c);
                  end
               end
            end
            PH_ZERO: begin
               if (c == "x" || c == "X") begin
                  radix = RX_HEX;
                  phase = PH_HEX;
               end else begin
                  radix = RX_OCT;
                  phase = PH_OCT;
                  octal_char(c);
               end
            end
            PH_DEC: begin
               if (is_dig(c)) add_digit(c, 64'd10);
               else int_end(c);
            end
            PH_OCT: octal_char(c);
            PH_BIG: begin
               if (is_dig(c)) begin
               end else if (c == "." || c == "e" || c == "E") begin
                  radix = RX_DEC;
                  int_end(c);
               end else begin
                  fail_with(ERR_DIGIT);
               end
            end
            PH_HEX: begin
               if (is_hex(c)) add_digit(c, 64'd16);
               else hex_end(c);
            end
            PH_FRAC: begin
               if (radix == RX_HEX) begin
                  if (!is_hex(c)) hex_end(c);
               end else if (!is_dig(c)) begin
                  if (c == "e" || c == "E") begin
                     flags.expo = 1'b1;
                     phase = PH_EXPSIGN;
                  end else begin
                     suffix_char(c);
                  end
               end
            end
            PH_EXPSIGN: begin
               if (c == "+" || c == "-") phase = PH_EXPDIG0;
               else if (is_dig(c)) phase = PH_EXPDIG;
               else fail_with(ERR_EXP);
            end
            PH_EXPDIG0: begin
               if (is_dig(c)) phase = PH_EXPDIG;
               else fail_with(ERR_EXP);
            end
            PH_EXPDIG: begin
               if (!is_dig(c)) suffix_char(c);
            end
            PH_SUFFIX: suffix_char(c);
            default: ;
         endcase
      endfunction

      // accepted character: advance the scan, predict the result on the last one
      function void take_char(req_type item);
         rsp_type want;
         bit valid_int;
         advance_scan(item.ch);
         if (!item.last) return;
         // token ends in the middle of a part
         if (phase == PH_BIG) fail_with(ERR_DIGIT);
         else if (phase == PH_EXPSIGN || phase == PH_EXPDIG0) fail_with(ERR_EXP);
         else if (phase == PH_FRAC && radix == RX_HEX) fail_with(ERR_HEX_EXP);
         if (phase != PH_ERR && pend_l != 8'h00) begin
            flags.lng = 1'b1;
            pend_l = 8'h00;
         end
         // a zero with no octal digits after it stays decimal
         if ((errc == ERR_NONE || errc == ERR_SUFFIX) && (radix == RX_OCT || phase == PH_ZERO)
               && ndigits == 5'd0 && radix != RX_HEX)
            radix = RX_DEC;
         valid_int = errc == ERR_NONE && !fp_token();
         want.base = radix;
         want.has_point = flags.point;
         want.has_exp = flags.expo;
         want.sfx_unsigned = flags.uns;
         want.sfx_long = flags.lng;
         want.sfx_long_long = flags.llng;
         want.sfx_float = flags.flt;
         want.err = errc;
         want.int_value = valid_int ? acc : '0;
         want.overflow = valid_int && ovf;
         due_results.push_back(want);
         clear();
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result item with no token outstanding");
            failures++;
            return;
         end
         want = due_results.pop_front();
         compare("base", want.base, got.base);
         compare("has_point", want.has_point, got.has_point);
         compare("has_exp", want.has_exp, got.has_exp);
         compare("sfx_unsigned", want.sfx_unsigned, got.sfx_unsigned);
         compare("sfx_long", want.sfx_long, got.sfx_long);
         compare("sfx_long_long", want.sfx_long_long, got.sfx_long_long);
         compare("sfx_float", want.sfx_float, got.sfx_float);
         compare("err", want.err, got.err);
         compare("int_value", want.int_value, got.int_value);
         compare("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   literal_tracker literals;
   logic [7:0] token_chars[$];
   int chars_sent = 0;
   int quiet_cycles = 0;
   bit steady = 1'b0;

   numeric_literal_scanner dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check accepted items, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) literals.check_result(rsp_data);
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("numeric_literal_scanner_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] rand_digit(int rdx);
      string hex_set;
      hex_set = "0123456789abcdefABCDEF";
      if (rdx == 8) return "0" + 8'($urandom_range(7));
      if (rdx == 10) return "0" + 8'($urandom_range(9));
      return hex_set[$urandom_range(21)];
   endfunction

   function automatic void push_digits(int n, int rdx);
      repeat (n) token_chars.push_back(rand_digit(rdx));
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
   endfunction

   function automatic void push_sign();
      case ($urandom_range(2))
         0: token_chars.push_back("+");
         1: token_chars.push_back("-");
         default: ;
      endcase
   endfunction

   // mostly well-formed literals with random content, some noise and damage
   function automatic void make_token();
      string int_sfx[] = '{"", "", "u", "U", "l", "L", "ll", "LL", "ul", "Lu", "ull",
                           "LLU", "lL", "uu", "lll", "f"};
      string flt_sfx[] = '{"", "", "f", "F", "l", "L", "fl", "ff", "u", "ll", "x"};
      int len;
      bit is_int;
      token_chars.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 4)) token_chars.push_back(8'($urandom_range(255)));
         return;
      end
      // long runs can push the value past 64 bits
      len = ($urandom_range(7) == 0) ? $urandom_range(17, 23) : $urandom_range(0, 6);
      is_int = 1'b1;
      case ($urandom_range(4))
         0: begin
            token_chars.push_back("1" + 8'($urandom_range(8)));
            push_digits(len, 10);
         end
         1: begin
            // octal, now and then with an 8 or 9 that a period or exponent may rescue
            push_text("0");
            push_digits(len, 8);
            if ($urandom_range(2) == 0) begin
               is_int = 1'b0;
               token_chars.push_back($urandom_range(1) ? "8" : "9");
               push_digits($urandom_range(2), 10);
               case ($urandom_range(3))
                  0: push_text(".");
                  1: push_text("e");
                  2: push_text("E+");
                  default: ;
               endcase
               push_digits($urandom_range(2), 10);
            end
         end
         2: begin
            push_text("0");
            token_chars.push_back($urandom_range(1) ? "x" : "X");
            push_digits(len, 16);
            if ($urandom_range(2) == 0) begin
               is_int = 1'b0;
               if ($urandom_range(3) != 0) begin
                  push_text(".");
                  push_digits($urandom_range(3), 16);
               end
               if ($urandom_range(4) != 0) begin
                  token_chars.push_back($urandom_range(1) ? "p" : "P");
                  push_sign();
                  push_digits($urandom_range(3), 10);
               end
            end
         end
         3: begin
            is_int = 1'b0;
            push_digits($urandom_range(3), 10);
            if ($urandom_range(3) != 0) begin
               push_text(".");
               push_digits($urandom_range(3), 10);
            end
            if ($urandom_range(1)) begin
               token_chars.push_back($urandom_range(1) ? "e" : "E");
               push_sign();
               push_digits($urandom_range(3), 10);
            end
         end
         default: push_text("0");
      endcase
      if (is_int) push_text(int_sfx[$urandom_range(int_sfx.size() - 1)]);
      else push_text(flt_sfx[$urandom_range(flt_sfx.size() - 1)]);
      if (token_chars.size() == 0) push_text("0");
      // a stray byte somewhere in the token
      if ($urandom_range(9) == 0)
         token_chars[$urandom_range(token_chars.size() - 1)] = 8'($urandom_range(255));
   endfunction

   // one character item; valid stays high across back-to-back items
   task automatic send_char(input logic [7:0] c, input logic is_last);
      req_type item;
      item.ch = c;
      item.last = is_last;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      literals.take_char(item);
      chars_sent++;
   endtask

   task automatic send_token();
      foreach (token_chars[i]) send_char(token_chars[i], i == token_chars.size() - 1);
   endtask

   // hold off the sender until every token has its result
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (literals.due_results.size() != 0);
   endtask

   initial begin
      string directed[] = '{"0", "0x", "09.", "09", "0f", "7uLL", "1e", "0x1.", "2.f", "5l"};
      bit mid_drain_done;
      mid_drain_done = 1'b0;
      literals = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed tokens, then the byte extremes as tokens of their own
      foreach (directed[i]) begin
         token_chars.delete();
         push_text(directed[i]);
         send_token();
      end
      token_chars = '{8'h00};
      send_token();
      token_chars = '{8'hff};
      send_token();
      wait_drained();

      // random tokens, with a stretch of no idling on either side
      while (chars_sent < CHAR_TARGET) begin
         steady = chars_sent >= 250 && chars_sent < 450;
         if (!mid_drain_done && chars_sent >= 500) begin
            wait_drained();
            mid_drain_done = 1'b1;
         end
         make_token();
         send_token();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (literals.due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (literals.failures == 0)
         $display("numeric_literal_scanner_test OK");
      else
         $display("numeric_literal_scanner_test NOT OK");
      $finish;
   end

endmodule

[filelist.f]
src/nls_pkg.sv
src/numeric_literal_scanner.sv
src/nls_checker.sv
tb/numeric_literal_scanner_test.sv
